// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge, masked while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- sv/mepi_pkg.sv -----
package mepi_pkg;

  // Exponent register width; only the low EXP_BITS bits of an exponent count.
  localparam int EXP_BITS = 32;
  localparam int RES_W    = 30;

  typedef logic [RES_W-1:0]    res_t;
  typedef logic [EXP_BITS-1:0] exp_t;

  // Prime modulus and Barrett constant floor(2^60 / P).
  localparam res_t        PRIME_MOD  = 30'd1000000007;
  localparam logic [31:0] PRIME_X2   = 32'd2000000014;
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  // Exponent used for the Fermat inverse: P - 2.
  localparam exp_t FERMAT_EXP = exp_t'(32'd1000000005);

  // Opcodes.
  localparam logic OP_POWER   = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch a new item
    logic issue_mul;  // start acc * sq
    logic issue_sqr;  // start sq * sq
    logic wr_acc;     // take multiplier result into acc
    logic wr_sq;      // take multiplier result into sq
    logic shift;      // drop the exponent LSB
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_zero;
    logic exp_one;
    logic exp_lsb;
    logic mm_done;
  } dp_stat_t;

endpackage

// ----- sv/mepi_modmul.sv -----
`include "assert_macros.svh"

// Pipelined modular multiplier, Barrett reduction.
module mepi_modmul import mepi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  res_t op_a,
  input  res_t op_b,
  output logic res_valid,
  output res_t res
);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [59:0] prod_r, prod_nxt;
  logic [61:0] q2_r, q2_nxt;
  logic [31:0] xlo2_r, xlo3_r;
  logic [31:0] qp_r, qp_nxt;
  logic [60:0] qp_full;
  logic [31:0] diff;
  res_t        res_r, res_nxt;

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage 1: full product
  assign prod_nxt = op_a * op_b;

  // Stage 2: quotient estimate q1 * mu, q1 = x >> 29
  assign q2_nxt = prod_r[59:29] * BARRETT_MU;

  // Stage 3: q3 * P, low 32 bits suffice since remainder < 3P
  assign qp_full = q2_r[61:31] * PRIME_MOD;
  assign qp_nxt  = qp_full[31:0];

  // Stage 4: remainder and up to two corrections
  assign diff = xlo3_r - qp_r;
  always_comb begin
    if (diff >= PRIME_X2) begin
      res_nxt = 30'(diff - PRIME_X2);
    end else if (diff >= {2'b00, PRIME_MOD}) begin
      res_nxt = 30'(diff - {2'b00, PRIME_MOD});
    end else begin
      res_nxt = diff[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    q2_r   <= q2_nxt;
    xlo2_r <= prod_r[31:0];
    qp_r   <= qp_nxt;
    xlo3_r <= xlo2_r;
    res_r  <= res_nxt;
  end

  assign res_valid = v4_r;
  assign res       = res_r;

  `ASSERT_CLK(a_mm_latency, clk, rst_n, in_valid |-> ##4 v4_r, "modmul result missing")
  `ASSERT_CLK(a_mm_range, clk, rst_n, v4_r |-> (res_r < PRIME_MOD), "modmul result not reduced")
  `ASSERT_NEVER(a_mm_one_in_flight, clk, rst_n, in_valid && (v1_r || v2_r || v3_r), "modmul issued while busy")

endmodule

// ----- sv/mepi_dp.sv -----
// Datapath: operand registers, base reduction and the shared multiplier.
module mepi_dp import mepi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_opcode,
  input  res_t        in_base,
  input  logic [31:0] in_exponent,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output res_t        result
);

  res_t acc_r, acc_nxt;
  res_t sq_r, sq_nxt;
  exp_t exp_r, exp_nxt;
  res_t base_red;
  logic inv_trivial;
  res_t mm_a;
  logic mm_valid;
  res_t mm_res;

  // Base below 2^30 < 2P: one conditional subtract reduces it
  assign base_red    = (in_base >= PRIME_MOD) ? (in_base - PRIME_MOD) : in_base;
  // Inverse of zero or one answers 1 with no multiplies
  assign inv_trivial = (in_opcode == OP_INVERSE) && (base_red <= res_t'(1));

  // Shared multiplier
  assign mm_a = cmd.issue_sqr ? sq_r : acc_r;

  mepi_modmul u_modmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.issue_mul | cmd.issue_sqr),
    .op_a      (mm_a),
    .op_b      (sq_r),
    .res_valid (mm_valid),
    .res       (mm_res)
  );

  // Next values of the working registers
  always_comb begin
    acc_nxt = acc_r;
    sq_nxt  = sq_r;
    exp_nxt = exp_r;
    if (cmd.load) begin
      acc_nxt = res_t'(1);
      sq_nxt  = base_red;
      if (inv_trivial) begin
        exp_nxt = '0;
      end else if (in_opcode == OP_INVERSE) begin
        exp_nxt = FERMAT_EXP;
      end else begin
        exp_nxt = exp_t'(in_exponent);
      end
    end else begin
      if (cmd.wr_acc) begin
        acc_nxt = mm_res;
      end
      if (cmd.wr_sq) begin
        sq_nxt = mm_res;
      end
      if (cmd.shift) begin
        exp_nxt = exp_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    exp_r <= exp_nxt;
  end

  assign stat.exp_zero = (exp_r == '0);
  assign stat.exp_one  = (exp_r == exp_t'(1));
  assign stat.exp_lsb  = exp_r[0];
  assign stat.mm_done  = mm_valid;
  assign result        = acc_r;

endmodule

// ----- sv/mepi_ctrl.sv -----
`include "assert_macros.svh"

// Controller: walks the exponent LSB first, sequencing the shared multiplier.
module mepi_ctrl import mepi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     out_valid
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_CHECK    = 6'b000010,
    S_MUL_WAIT = 6'b000100,
    S_SHIFT    = 6'b001000,
    S_SQR_WAIT = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.exp_zero) begin
          state_nxt = S_DONE;
        end else if (stat.exp_lsb) begin
          cmd.issue_mul = 1'b1;
          state_nxt     = S_MUL_WAIT;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_MUL_WAIT: begin
        if (stat.mm_done) begin
          cmd.wr_acc = 1'b1;
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // last set bit consumed: the square would go unused
        cmd.shift = 1'b1;
        if (stat.exp_one) begin
          state_nxt = S_DONE;
        end else begin
          cmd.issue_sqr = 1'b1;
          state_nxt     = S_SQR_WAIT;
        end
      end
      S_SQR_WAIT: begin
        if (stat.mm_done) begin
          cmd.wr_sq = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  `ASSERT_CLK(a_done_only_waiting, clk, rst_n,
    stat.mm_done |-> (state_r == S_MUL_WAIT || state_r == S_SQR_WAIT),
    "multiplier result arrived outside a wait state")
  `ASSERT_CLK(a_start_takes, clk, rst_n, (start && !busy) |=> busy, "start not taken")
  `ASSERT_NEVER(a_issue_overlap, clk, rst_n, cmd.issue_mul && cmd.issue_sqr,
    "two multiplies issued at once")

endmodule

// ----- sv/modular_exponentiation_inverse_core.sv -----
// Channel   Ports                                   Transfer
// input     in_opcode, in_base, in_exponent         start high and busy low
// result    out_result                              out_valid high, one cycle
//
// One item at a time, exponent walked LSB first on one shared multiplier
// (four-stage Barrett pipeline, one operation in flight). No square is issued
// after the highest set bit, and a zero exponent or an inverse of 0/1 issues
// no multiplies. Synchronous active-low reset returns to idle. The result is
// driven for one cycle and cannot be stalled.
module modular_exponentiation_inverse_core import mepi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [29:0] in_base,
  input  logic [31:0] in_exponent,
  output logic        out_valid,
  output logic [29:0] out_result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mepi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mepi_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_opcode   (in_opcode),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .cmd         (cmd),
    .stat        (stat),
    .result      (out_result)
  );

endmodule

// ----- dv/tb_modular_exponentiation_inverse_core.sv -----
`timescale 1ns / 100ps

module tb_modular_exponentiation_inverse_core;
  import mepi_pkg::*;

  typedef longint unsigned u64_t;

  localparam u64_t        MODULUS  = u64_t'(PRIME_MOD);
  localparam logic [29:0] BASE_PM1 = 30'd1000000006;
  localparam logic [29:0] BASE_P   = 30'd1000000007;
  localparam logic [29:0] BASE_PP1 = 30'd1000000008;
  localparam logic [29:0] BASE_TOP = 30'h3FFFFFFF;
  localparam logic [31:0] EXP_TOP  = 32'hFFFFFFFF;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [29:0] in_base;
  logic [31:0] in_exponent;
  logic        out_valid;
  logic [29:0] out_result;

  // expected residues, oldest first
  res_t residue_q[$];
  int   fail_count    = 0;
  int   checked_count = 0;
  int   power_count   = 0;
  int   inverse_count = 0;
  int   pause_count   = 0;

  modular_exponentiation_inverse_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_opcode  (in_opcode),
    .in_base    (in_base),
    .in_exponent(in_exponent),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Right-to-left square-and-multiply mod the prime, base reduced first.
  function automatic res_t predict_residue(input logic op, input logic [29:0] base,
                                           input logic [31:0] exponent);
    u64_t acc;
    u64_t sq;
    exp_t e;
    acc = 1;
    sq  = u64_t'(base) % MODULUS;
    if (op == OP_INVERSE) begin
      // zero and one both come back as 1
      if (sq <= 1) return res_t'(1);
      e = FERMAT_EXP;
    end else begin
      e = exp_t'(exponent);
    end
    for (int i = 0; i < EXP_BITS; i++) begin
      if (e[i]) acc = (acc * sq) % MODULUS;
      sq = (sq * sq) % MODULUS;
    end
    return res_t'(acc);
  endfunction

  // Idle cycles after a transfer: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Mostly reduced residues, some tiny ones, some above the modulus.
  function automatic logic [29:0] pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 30'($urandom_range(0, 3));
    if (r == 1) return 30'($urandom);
    if (r == 2) return 30'($urandom_range(1000000003, 1073741823));
    return 30'($urandom_range(0, 1000000006));
  endfunction

  // Random significant width so short and long exponent walks both occur.
  function automatic logic [31:0] pick_exponent();
    int          nbits;
    logic [31:0] mask;
    nbits = $urandom_range(0, 32);
    mask  = (nbits == 32) ? EXP_TOP : ((32'd1 << nbits) - 32'd1);
    return $urandom & mask;
  endfunction

  // Inverse takes the full Fermat walk, so keep it to about a quarter.
  function automatic logic pick_opcode();
    return ($urandom_range(0, 3) == 0) ? OP_INVERSE : OP_POWER;
  endfunction

  // One transfer; start stays high when no gap follows.
  task automatic send_item(input logic op, input logic [29:0] base,
                           input logic [31:0] exponent, input int gap);
    start       <= 1'b1;
    in_opcode   <= op;
    in_base     <= base;
    in_exponent <= exponent;
    do @(posedge clk); while (busy);
    residue_q = {residue_q, predict_residue(op, base, exponent)};
    if (op == OP_INVERSE) inverse_count++;
    else power_count++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every pending result is back, then a short tail.
  task automatic wait_drained(input int tail);
    start <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Field extremes, unreduced bases, zero exponent, inverse of 0 and 1.
  task automatic test_corner_cases();
    send_item(OP_POWER, 30'd0, 32'd0, pick_gap());
    send_item(OP_POWER, BASE_PM1, 32'd0, pick_gap());
    send_item(OP_POWER, 30'd0, 32'd5, pick_gap());
    send_item(OP_POWER, 30'd0, EXP_TOP, pick_gap());
    send_item(OP_POWER, 30'd1, EXP_TOP, pick_gap());
    send_item(OP_POWER, BASE_PM1, 32'd2, pick_gap());
    send_item(OP_POWER, BASE_PM1, 32'd3, pick_gap());
    send_item(OP_POWER, BASE_P, 32'd3, pick_gap());
    send_item(OP_POWER, BASE_PP1, EXP_TOP, pick_gap());
    send_item(OP_POWER, BASE_TOP, EXP_TOP, pick_gap());
    send_item(OP_POWER, 30'd2, 32'd1, pick_gap());
    send_item(OP_POWER, 30'd2, 32'd31, pick_gap());
    send_item(OP_POWER, 30'd2, 32'h80000000, pick_gap());
    send_item(OP_POWER, 30'h15555555, 32'h55555555, pick_gap());
    send_item(OP_POWER, 30'h2AAAAAAA, 32'hAAAAAAAA, pick_gap());
    send_item(OP_INVERSE, 30'd0, 32'd0, pick_gap());
    send_item(OP_INVERSE, 30'd1, 32'd0, pick_gap());
    send_item(OP_INVERSE, BASE_P, 32'd7, pick_gap());
    send_item(OP_INVERSE, BASE_PP1, EXP_TOP, pick_gap());
    send_item(OP_INVERSE, 30'd2, EXP_TOP, pick_gap());
    send_item(OP_INVERSE, BASE_PM1, 32'd0, pick_gap());
    send_item(OP_INVERSE, BASE_TOP, 32'd0, pick_gap());
    send_item(OP_INVERSE, 30'h2AAAAAAA, 32'h55555555, 0);
    wait_drained(4);
  endtask

  // Sender stops until the block has returned everything, then resumes.
  task automatic test_drain_pause();
    repeat (5) send_item(pick_opcode(), pick_base(), pick_exponent(), pick_gap());
    wait_drained(0);
    pause_count++;
    repeat (5) send_item(pick_opcode(), pick_base(), pick_exponent(), 0);
    wait_drained(4);
  endtask

  // Start held high across items: no idle cycles on the input side.
  task automatic test_back_to_back();
    repeat (24) send_item(pick_opcode(), pick_base(), pick_exponent(), 0);
    wait_drained(4);
  endtask

  // Bulk random traffic with the odd full drain in between.
  task automatic test_random_mix(input int count);
    for (int n = 0; n < count; n++) begin
      send_item(pick_opcode(), pick_base(), pick_exponent(), pick_gap());
      if ($urandom_range(0, 59) == 0) begin
        wait_drained($urandom_range(0, 3));
        pause_count++;
      end
    end
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (residue_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result %0d with nothing pending", $time, out_result);
      end else begin
        if (out_result !== residue_q[0]) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result expected %0d, got %0d", $time, residue_q[0], out_result);
        end
        void'(residue_q.pop_front());
        checked_count++;
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_opcode   <= OP_POWER;
    in_base     <= '0;
    in_exponent <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_cases();
    test_drain_pause();
    test_back_to_back();
    test_random_mix(1250);
    // wait out the longest walk to catch any stray strobe
    wait_drained(400);

    $display("covered %0d power and %0d inverse transfers, %0d results compared",
             power_count, inverse_count, checked_count);
    $display("sender drained the block %0d times; %0d failures", pause_count, fail_count);
    if (fail_count == 0) begin
      $display("modular_exponentiation_inverse_core: match");
    end else begin
      $display("modular_exponentiation_inverse_core: mismatch");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #20000000;
    $display("timeout waiting on the block");
    $display("modular_exponentiation_inverse_core: mismatch");
    $finish;
  end

endmodule
